/* rtl/core/cgemv_pkg.sv */
// Shared constants, types and helpers for the complex column MAC.
package cgemv_pkg;

  localparam int DATA_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 12;
  localparam int ACC_WIDTH_DEF  = 48;

  localparam int CFG_ADDR_W = 2;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_ALPHA_RE   = 2'd0,
    CFG_ALPHA_IM   = 2'd1,
    CFG_CONJ_MODE  = 2'd2,
    CFG_XCONJ_MODE = 2'd3
  } cfg_idx_t;

  // operand selection of the two multiplier lanes
  typedef enum logic [1:0] {
    PH_ACC_A,
    PH_ACC_B,
    PH_ALP_A,
    PH_ALP_B
  } mul_phase_t;

  typedef struct packed {
    logic       load_in;
    logic       mul_en;
    mul_phase_t phase;
    logic       top_chunk;
    logic       sum_add;
    logic       t_load;
    logic       u_shift_add;
    logic       u_add;
    logic       out_load;
  } cmd_t;

  // width of the rounding stage for the column sums
  function automatic int round_width(int fw, int aw);
    return ((aw > fw + 1) ? aw : fw + 1) + 1;
  endfunction

  // width of the rounded column sum after clamping
  function automatic int t_width(int dw, int fw, int aw);
    int ew;
    int cl;
    ew = round_width(fw, aw);
    cl = 62 - dw;
    return (ew < cl) ? ew : cl;
  endfunction

endpackage

/* rtl/core/cgemv_ctrl.sv */
// Sequencer for the column MAC: accumulate steps, alpha scaling chunks, result hand-off.
module cgemv_ctrl #(
  parameter int CHUNKS = 3
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  input  logic            last_in,
  output cgemv_pkg::cmd_t cmd
);
  import cgemv_pkg::*;

  localparam int CW = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam logic [CW-1:0] TOP = CW'(CHUNKS - 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACC_A,
    S_ACC_B,
    S_ACC_C,
    S_RND,
    S_ALP_A,
    S_ALP_B,
    S_ALP_C,
    S_OUT
  } state_t;

  state_t        state_r;
  logic [CW-1:0] cnt_r;
  logic          out_valid_r;
  logic          out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // a new result may replace the one leaving in the same cycle
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) state_r <= S_ACC_A;
        end
        S_ACC_A: state_r <= S_ACC_B;
        S_ACC_B: state_r <= S_ACC_C;
        S_ACC_C: state_r <= last_in ? S_RND : S_IDLE;
        S_RND: begin
          cnt_r   <= TOP;
          state_r <= S_ALP_A;
        end
        S_ALP_A: state_r <= S_ALP_B;
        S_ALP_B: state_r <= S_ALP_C;
        S_ALP_C: begin
          if (cnt_r == '0) begin
            state_r <= S_OUT;
          end else begin
            cnt_r   <= cnt_r - 1'b1;
            state_r <= S_ALP_A;
          end
        end
        S_OUT: begin
          if (out_free) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE:  cmd.load_in = in_tvalid;
      S_ACC_A: begin
        cmd.mul_en = 1'b1;
        cmd.phase  = PH_ACC_A;
      end
      S_ACC_B: begin
        cmd.sum_add = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.phase   = PH_ACC_B;
      end
      S_ACC_C: cmd.sum_add = 1'b1;
      S_RND:   cmd.t_load  = 1'b1;
      S_ALP_A: begin
        cmd.mul_en    = 1'b1;
        cmd.phase     = PH_ALP_A;
        cmd.top_chunk = (cnt_r == TOP);
      end
      S_ALP_B: begin
        cmd.u_shift_add = 1'b1;
        cmd.mul_en      = 1'b1;
        cmd.phase       = PH_ALP_B;
        cmd.top_chunk   = (cnt_r == TOP);
      end
      S_ALP_C: cmd.u_add    = 1'b1;
      S_OUT:   cmd.out_load = out_free;
      default: cmd = '0;
    endcase
  end

endmodule

/* rtl/core/cgemv_dp.sv */
// Datapath: config registers, two multiplier lanes, accumulators, alpha scaling, output rounding.
module cgemv_dp #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 12,
  parameter int ACC_WIDTH  = 48
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [cgemv_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [DATA_WIDTH-1:0]               cfg_wdata,
  input  logic signed [DATA_WIDTH-1:0]        mat_re,
  input  logic signed [DATA_WIDTH-1:0]        mat_im,
  input  logic signed [DATA_WIDTH-1:0]        vec_re,
  input  logic signed [DATA_WIDTH-1:0]        vec_im,
  input  logic signed [DATA_WIDTH-1:0]        old_y_re,
  input  logic signed [DATA_WIDTH-1:0]        old_y_im,
  input  logic                                last_in_column,
  input  cgemv_pkg::cmd_t                     cmd,
  output logic                                last_out,
  output logic signed [DATA_WIDTH-1:0]        new_y_re,
  output logic signed [DATA_WIDTH-1:0]        new_y_im,
  output logic                                saturated
);
  import cgemv_pkg::*;

  localparam int DW  = DATA_WIDTH;
  localparam int OW  = DW + 1;
  localparam int PW  = 2 * OW;
  localparam int SW  = ((ACC_WIDTH > PW) ? ACC_WIDTH : PW) + 1;
  localparam int EW  = round_width(FRAC_BITS, ACC_WIDTH);
  localparam int TW  = t_width(DW, FRAC_BITS, ACC_WIDTH);
  localparam int NCH = (TW + DW - 1) / DW;
  localparam int TXW = NCH * DW;
  localparam int UW0 = DW + TW + 2;
  localparam int UW  = (UW0 > PW + 1) ? UW0 : PW + 1;
  localparam int RW  = ((UW > FRAC_BITS + 1) ? UW : FRAC_BITS + 1) + 1;
  localparam int YW  = RW + 1;
  localparam int RIDX = (FRAC_BITS > 0) ? FRAC_BITS - 1 : 0;

  localparam logic signed [SW-1:0] ACC_MAX =
    $signed({{(SW - ACC_WIDTH + 1){1'b0}}, {(ACC_WIDTH - 1){1'b1}}});
  localparam logic signed [SW-1:0] ACC_MIN = ~ACC_MAX;
  localparam logic signed [EW-1:0] T_MAX =
    $signed({{(EW - TW + 1){1'b0}}, {(TW - 1){1'b1}}});
  localparam logic signed [EW-1:0] T_MIN = ~T_MAX;
  localparam logic signed [YW-1:0] D_MAX =
    $signed({{(YW - DW + 1){1'b0}}, {(DW - 1){1'b1}}});
  localparam logic signed [YW-1:0] D_MIN = ~D_MAX;
  localparam logic [DW-1:0] ALPHA_ONE = DW'(64'd1 << FRAC_BITS);

  // configuration
  logic signed [DW-1:0] alpha_re_r, alpha_im_r;
  logic                 conj_r, xconj_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_re_r <= ALPHA_ONE;
      alpha_im_r <= '0;
      conj_r     <= 1'b0;
      xconj_r    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_ALPHA_RE:   alpha_re_r <= cfg_wdata;
        CFG_ALPHA_IM:   alpha_im_r <= cfg_wdata;
        CFG_CONJ_MODE:  conj_r     <= cfg_wdata[0];
        CFG_XCONJ_MODE: xconj_r    <= cfg_wdata[0];
      endcase
    end
  end

  // input beat
  logic signed [DW-1:0] mr_r, mi_r, xr_r, xi_r, yr_r, yi_r;
  logic                 last_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mr_r   <= mat_re;
      mi_r   <= mat_im;
      xr_r   <= vec_re;
      xi_r   <= vec_im;
      yr_r   <= old_y_re;
      yi_r   <= old_y_im;
      last_r <= last_in_column;
    end
  end

  assign last_out = last_r;

  // operands
  logic signed [OW-1:0] mr_e, mim_e, xr_e, xi_e, nxi_e;
  logic signed [OW-1:0] ar_e, ai_e, nar_e, nai_e;
  logic signed [OW-1:0] ct_re, ct_im;
  logic [DW-1:0]        ch_re, ch_im;
  logic signed [TXW-1:0] t_re_r, t_im_r;

  assign mr_e  = OW'(mr_r);
  // matrix element conjugated when exactly one mode bit is set
  assign mim_e = (conj_r ^ xconj_r) ? -OW'(mi_r) : OW'(mi_r);
  assign xr_e  = OW'(xr_r);
  assign xi_e  = OW'(xi_r);
  assign nxi_e = -xi_e;
  assign ar_e  = OW'(alpha_re_r);
  assign ai_e  = OW'(alpha_im_r);
  assign nar_e = -ar_e;
  assign nai_e = -ai_e;

  // t is consumed top chunk first; only that chunk carries the sign
  assign ch_re = t_re_r[TXW-1 -: DW];
  assign ch_im = t_im_r[TXW-1 -: DW];
  assign ct_re = cmd.top_chunk ? $signed({ch_re[DW-1], ch_re}) : $signed({1'b0, ch_re});
  assign ct_im = cmd.top_chunk ? $signed({ch_im[DW-1], ch_im}) : $signed({1'b0, ch_im});

  logic signed [OW-1:0] a_re, b_re, a_im, b_im;

  always_comb begin
    unique case (cmd.phase)
      PH_ACC_A: begin
        a_re = mr_e;  b_re = xr_e;
        a_im = mr_e;  b_im = xi_e;
      end
      PH_ACC_B: begin
        a_re = mim_e; b_re = nxi_e;
        a_im = mim_e; b_im = xr_e;
      end
      PH_ALP_A: begin
        a_re = ar_e;  b_re = ct_re;
        a_im = xconj_r ? ai_e : ar_e;
        b_im = xconj_r ? ct_re : ct_im;
      end
      PH_ALP_B: begin
        a_re = xconj_r ? ai_e : nai_e;
        b_re = ct_im;
        a_im = xconj_r ? nar_e : ai_e;
        b_im = xconj_r ? ct_im : ct_re;
      end
      default: begin
        a_re = mr_e;  b_re = xr_e;
        a_im = mr_e;  b_im = xi_e;
      end
    endcase
  end

  logic signed [PW-1:0] mul_re, mul_im, p_re_r, p_im_r;

  assign mul_re = a_re * b_re;
  assign mul_im = a_im * b_im;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      p_re_r <= mul_re;
      p_im_r <= mul_im;
    end
  end

  // saturating accumulate
  logic signed [ACC_WIDTH-1:0] sum_re_r, sum_im_r, sat_re, sat_im;
  logic signed [SW-1:0]        s_re, s_im;

  assign s_re = SW'(sum_re_r) + SW'(p_re_r);
  assign s_im = SW'(sum_im_r) + SW'(p_im_r);

  always_comb begin
    priority if (s_re > ACC_MAX) sat_re = ACC_WIDTH'(ACC_MAX);
    else if (s_re < ACC_MIN)     sat_re = ACC_WIDTH'(ACC_MIN);
    else                         sat_re = ACC_WIDTH'(s_re);
    priority if (s_im > ACC_MAX) sat_im = ACC_WIDTH'(ACC_MAX);
    else if (s_im < ACC_MIN)     sat_im = ACC_WIDTH'(ACC_MIN);
    else                         sat_im = ACC_WIDTH'(s_im);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_re_r <= '0;
      sum_im_r <= '0;
    end else if (cmd.t_load) begin
      sum_re_r <= '0;
      sum_im_r <= '0;
    end else if (cmd.sum_add) begin
      sum_re_r <= sat_re;
      sum_im_r <= sat_im;
    end
  end

  // column sum rounded to FRAC_BITS, then clamped to TW bits
  logic signed [EW-1:0] se_re, se_im, tr_re, tr_im;
  logic signed [TW-1:0] tc_re, tc_im;
  logic                 rb_re, rb_im;

  assign se_re = EW'(sum_re_r);
  assign se_im = EW'(sum_im_r);
  assign rb_re = (FRAC_BITS > 0) ? se_re[RIDX] : 1'b0;
  assign rb_im = (FRAC_BITS > 0) ? se_im[RIDX] : 1'b0;
  assign tr_re = (se_re >>> FRAC_BITS) + $signed({{(EW - 1){1'b0}}, rb_re});
  assign tr_im = (se_im >>> FRAC_BITS) + $signed({{(EW - 1){1'b0}}, rb_im});

  always_comb begin
    priority if (tr_re > T_MAX) tc_re = TW'(T_MAX);
    else if (tr_re < T_MIN)     tc_re = TW'(T_MIN);
    else                        tc_re = TW'(tr_re);
    priority if (tr_im > T_MAX) tc_im = TW'(T_MAX);
    else if (tr_im < T_MIN)     tc_im = TW'(T_MIN);
    else                        tc_im = TW'(tr_im);
  end

  // alpha product built MSB chunk first: u = (u << DW) + partials
  logic signed [UW-1:0] u_re_r, u_im_r;

  always_ff @(posedge clk) begin
    if (cmd.t_load) begin
      t_re_r <= TXW'(tc_re);
      t_im_r <= TXW'(tc_im);
      u_re_r <= '0;
      u_im_r <= '0;
    end else begin
      if (cmd.u_shift_add) begin
        u_re_r <= (u_re_r <<< DW) + UW'(p_re_r);
        u_im_r <= (u_im_r <<< DW) + UW'(p_im_r);
      end else if (cmd.u_add) begin
        u_re_r <= u_re_r + UW'(p_re_r);
        u_im_r <= u_im_r + UW'(p_im_r);
        t_re_r <= t_re_r <<< DW;
        t_im_r <= t_im_r <<< DW;
      end
    end
  end

  // final rounding, add old y, saturate
  logic signed [RW-1:0] ue_re, ue_im, ur_re, ur_im;
  logic signed [YW-1:0] ys_re, ys_im;
  logic signed [DW-1:0] yo_re, yo_im;
  logic                 hit_re, hit_im, ub_re, ub_im;

  assign ue_re = RW'(u_re_r);
  assign ue_im = RW'(u_im_r);
  assign ub_re = (FRAC_BITS > 0) ? ue_re[RIDX] : 1'b0;
  assign ub_im = (FRAC_BITS > 0) ? ue_im[RIDX] : 1'b0;
  assign ur_re = (ue_re >>> FRAC_BITS) + $signed({{(RW - 1){1'b0}}, ub_re});
  assign ur_im = (ue_im >>> FRAC_BITS) + $signed({{(RW - 1){1'b0}}, ub_im});
  assign ys_re = YW'(yr_r) + YW'(ur_re);
  assign ys_im = YW'(yi_r) + YW'(ur_im);

  always_comb begin
    hit_re = 1'b1;
    hit_im = 1'b1;
    priority if (ys_re > D_MAX) yo_re = DW'(D_MAX);
    else if (ys_re < D_MIN)     yo_re = DW'(D_MIN);
    else begin
      yo_re  = DW'(ys_re);
      hit_re = 1'b0;
    end
    priority if (ys_im > D_MAX) yo_im = DW'(D_MAX);
    else if (ys_im < D_MIN)     yo_im = DW'(D_MIN);
    else begin
      yo_im  = DW'(ys_im);
      hit_im = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      new_y_re  <= yo_re;
      new_y_im  <= yo_im;
      saturated <= hit_re | hit_im;
    end
  end

endmodule

/* rtl/core/complex_gemv_transposed_column_mac.sv */
// Top level of the complex transposed GEMV column multiply-accumulate block.
//
// Input beats carry one complex matrix element and its complex x element;
// in_tlast marks the last element of a column, and that beat also carries
// the old y value. Each beat's product is added into saturating 48-bit
// complex accumulators. On the last beat the sum is rounded, scaled by
// alpha (or applied conjugated when xconj_mode is set), added to old y and
// saturated; one result beat then leaves on the out_ channel with the
// clip flag in out_tuser, and the accumulators clear.
// A new input beat is taken only once the last one is through, as the two
// multiplier lanes do two products each, one step at a time. After a last
// beat the sum is rounded, then alpha scaling walks the C DATA_WIDTH-bit chunks
// of the rounded sum (C = 3 at default sizes) before the result goes out.
// The result sits in an output register; if the receiver stalls, the next
// column's beats are still taken until another result is ready.
// Configuration is written through cfg_we/cfg_addr/cfg_wdata while idle.
// Reset (rst_n low, synchronous) clears the accumulators, empties the output,
// and sets alpha to 1.0 with both mode bits off.
module complex_gemv_transposed_column_mac #(
  parameter int DATA_WIDTH = cgemv_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = cgemv_pkg::FRAC_BITS_DEF,
  parameter int ACC_WIDTH  = cgemv_pkg::ACC_WIDTH_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          cfg_we,
  input  logic [cgemv_pkg::CFG_ADDR_W-1:0]              cfg_addr,
  input  logic [DATA_WIDTH-1:0]                         cfg_wdata,
  input  logic                                          in_tvalid,
  output logic                                          in_tready,
  // mat_re, mat_im, vec_re, vec_im, old_y_re, old_y_im, zero fill
  input  logic [((6 * DATA_WIDTH + 7) / 8) * 8 - 1:0]   in_tdata,
  input  logic                                          in_tlast,
  output logic                                          out_tvalid,
  input  logic                                          out_tready,
  // new_y_re, new_y_im, zero fill
  output logic [((2 * DATA_WIDTH + 7) / 8) * 8 - 1:0]   out_tdata,
  // saturated
  output logic                                          out_tuser
);
  import cgemv_pkg::*;

  localparam int DW     = DATA_WIDTH;
  localparam int TW     = t_width(DW, FRAC_BITS, ACC_WIDTH);
  localparam int CHUNKS = (TW + DW - 1) / DW;
  localparam int OTW    = ((2 * DW + 7) / 8) * 8;

  cmd_t                 cmd;
  logic                 last_flag;
  logic signed [DW-1:0] new_y_re, new_y_im;

  cgemv_ctrl #(
    .CHUNKS (CHUNKS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .last_in    (last_flag),
    .cmd        (cmd)
  );

  cgemv_dp #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS),
    .ACC_WIDTH  (ACC_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .mat_re         ($signed(in_tdata[0 * DW +: DW])),
    .mat_im         ($signed(in_tdata[1 * DW +: DW])),
    .vec_re         ($signed(in_tdata[2 * DW +: DW])),
    .vec_im         ($signed(in_tdata[3 * DW +: DW])),
    .old_y_re       ($signed(in_tdata[4 * DW +: DW])),
    .old_y_im       ($signed(in_tdata[5 * DW +: DW])),
    .last_in_column (in_tlast),
    .cmd            (cmd),
    .last_out       (last_flag),
    .new_y_re       (new_y_re),
    .new_y_im       (new_y_im),
    .saturated      (out_tuser)
  );

  assign out_tdata = OTW'({new_y_im, new_y_re});

endmodule

/* test/testbench.sv */
// Self-checking testbench for the complex transposed GEMV column MAC.
module testbench;
  import cgemv_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int     DW          = DATA_WIDTH_DEF;
  localparam int     FRAC        = FRAC_BITS_DEF;
  localparam longint ACC_MAX     = (longint'(1) <<< (ACC_WIDTH_DEF - 1)) - 1;
  localparam longint Y_MAX       = (longint'(1) <<< (DW - 1)) - 1;
  localparam int     SETTLE      = 24;
  localparam int     CYCLE_LIMIT = 3_000_000;
  localparam int     PHASES      = 8;
  localparam int     PHASE_BEATS = 210;
  localparam int     SAT_RUN     = 40;        // enough extreme beats to clip y
  localparam int     NUM_DIR     = 20;

  typedef struct packed {
    logic signed [DW-1:0] mat_re;
    logic signed [DW-1:0] mat_im;
    logic signed [DW-1:0] vec_re;
    logic signed [DW-1:0] vec_im;
    logic signed [DW-1:0] oy_re;
    logic signed [DW-1:0] oy_im;
    logic                 last;
  } elem_t;

  typedef struct packed {
    logic signed [DW-1:0] re;
    logic signed [DW-1:0] im;
    logic                 sat;
  } y_result_t;

  // directed rows; a row with set_cfg first reprograms the block while idle
  typedef struct packed {
    bit set_cfg;
    int a_re;
    int a_im;
    bit cj;
    bit xcj;
    int m_re;
    int m_im;
    int v_re;
    int v_im;
    int y_re;
    int y_im;
    bit last;
    bit typed;
    int e_re;
    int e_im;
    bit e_sat;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
    '{0, 0, 0, 0, 0,      0,      0,      0,      0,   1234,     -5, 1, 1,  1234,     -5, 0},
    '{0, 0, 0, 0, 0,   4096,      0,   4096,      0,      0,      0, 1, 1,  4096,      0, 0},
    '{0, 0, 0, 0, 0,      0,   4096,      0,   4096,      0,      0, 1, 1, -4096,      0, 0},
    '{0, 0, 0, 0, 0,   4096,      0,   4096,      0,      0,      0, 0, 0,     0,      0, 0},
    '{0, 0, 0, 0, 0,   4096,      0,      0,   4096,      0,      0, 1, 1,  4096,   4096, 0},
    '{0, 0, 0, 0, 0,  32767,      0,  32767,      0,  32767,      0, 1, 1, 32767,      0, 1},
    '{0, 0, 0, 0, 0, -32768,      0,  32767,      0, -32768,      0, 1, 1, -32768,     0, 1},
    // half an LSB rounds up, minus half rounds up to zero
    '{0, 0, 0, 0, 0,      1,      0,   2048,      0,      0,      0, 1, 1,     1,      0, 0},
    '{0, 0, 0, 0, 0,     -1,      0,   2048,      0,      0,      0, 1, 1,     0,      0, 0},
    '{0, 0, 0, 0, 0, -32768, -32768, -32768, -32768,  32767, -32768, 1, 0,     0,      0, 0},
    '{0, 0, 0, 0, 0,  32767, -32768, -32768,  32767,     -1,      1, 1, 0,     0,      0, 0},
    // conj only, both modes, xconj only
    '{1, 4096, 0, 1, 0,   0,   4096,      0,   4096,      0,      0, 1, 1,  4096,      0, 0},
    '{1, 4096, 0, 1, 1, 4096,     0,      0,   4096,      0,      0, 1, 1,     0,  -4096, 0},
    '{1, 4096, 0, 0, 1,   0,   4096,   4096,      0,      0,      0, 1, 1,     0,   4096, 0},
    // zero alpha leaves y alone
    '{1, 0, 0, 0, 0,  32767,  32767,  32767, -32768,     -7,      9, 1, 1,    -7,      9, 0},
    '{1, -32768, 32767, 0, 0, 4096, 0,  4096,      0,      0,      0, 1, 1, -32768, 32767, 0},
    '{1, 32767, -32768, 1, 1, 4096, 0,     0,   4096,      0,      0, 1, 1, -32768, -32767, 0},
    '{0, 0, 0, 0, 0, -32768,  32767,  32767, -32768, -32768,  32767, 1, 0,     0,      0, 0},
    '{0, 0, 0, 0, 0,  12345, -23456,  -3210,  30000,      0,      0, 0, 0,     0,      0, 0},
    '{0, 0, 0, 0, 0,     -1,     -1,     -1,     -1,      5,     -5, 1, 0,     0,      0, 0}
  };

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  cfg_idx_t            cfg_addr;
  logic [DW-1:0]       cfg_wdata;
  logic                in_tvalid;
  logic                in_tready;
  logic [6*DW-1:0]     in_tdata;
  logic                in_tlast;
  logic                out_tvalid;
  logic                out_tready;
  logic [2*DW-1:0]     out_tdata;
  logic                out_tuser;

  // predictor state and its copy of the registers
  longint              col_sum_re;
  longint              col_sum_im;
  logic signed [DW-1:0] alpha_re_q;
  logic signed [DW-1:0] alpha_im_q;
  bit                  conj_q;
  bit                  xconj_q;

  y_result_t           y_expected_q [$];
  int                  mismatches;
  int                  cycle_count;
  int                  rx_left;
  int                  rx_mode;

  complex_gemv_transposed_column_mac i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #1 clk = ~clk;

  function automatic longint acc_add(longint a, longint b);
    longint s;
    s = a + b;
    if (s > ACC_MAX) return ACC_MAX;
    if (s < -ACC_MAX - 1) return -ACC_MAX - 1;
    return s;
  endfunction

  // round to nearest, ties toward plus infinity
  function automatic longint round_frac(longint v);
    return (v >>> FRAC) + (v[FRAC-1] ? longint'(1) : longint'(0));
  endfunction

  function automatic longint clip_y(longint v, inout bit hit);
    if (v > Y_MAX) begin
      hit = 1;
      return Y_MAX;
    end
    if (v < -Y_MAX - 1) begin
      hit = 1;
      return -Y_MAX - 1;
    end
    return v;
  endfunction

  // accumulate one element; on the column end, produce the updated y
  function automatic bit update_column(input elem_t e, output y_result_t r);
    longint ar, ai, xr, xi, t_re, t_im, alr, ali, u_re, u_im, y_re, y_im;
    bit hit;
    hit = 0;
    r = '0;
    ar = e.mat_re;
    ai = e.mat_im;
    xr = e.vec_re;
    xi = e.vec_im;
    if (conj_q ^ xconj_q) ai = -ai;
    // each product saturates on its own
    col_sum_re = acc_add(col_sum_re, ar * xr);
    col_sum_re = acc_add(col_sum_re, -(ai * xi));
    col_sum_im = acc_add(col_sum_im, ar * xi);
    col_sum_im = acc_add(col_sum_im, ai * xr);
    if (!e.last) return 0;
    t_re = round_frac(col_sum_re);
    t_im = round_frac(col_sum_im);
    alr = alpha_re_q;
    ali = alpha_im_q;
    if (!xconj_q) begin
      u_re = alr * t_re - ali * t_im;
      u_im = alr * t_im + ali * t_re;
    end else begin
      u_re = alr * t_re + ali * t_im;
      u_im = ali * t_re - alr * t_im;
    end
    y_re = clip_y(longint'(e.oy_re) + round_frac(u_re), hit);
    y_im = clip_y(longint'(e.oy_im) + round_frac(u_im), hit);
    r.re = y_re[DW-1:0];
    r.im = y_im[DW-1:0];
    r.sat = hit;
    col_sum_re = 0;
    col_sum_im = 0;
    return 1;
  endfunction

  function automatic logic signed [DW-1:0] rand_word();
    int k;
    int v;
    k = $urandom_range(0, 9);
    if (k == 0) v = -32768;
    else if (k == 1) v = 32767;
    else if (k <= 3) v = int'($urandom_range(0, 16384)) - 8192;
    else v = $urandom;
    return v[DW-1:0];
  endfunction

  function automatic elem_t rand_elem(bit last);
    elem_t e;
    e.mat_re = rand_word();
    e.mat_im = rand_word();
    e.vec_re = rand_word();
    e.vec_im = rand_word();
    e.oy_re  = rand_word();
    e.oy_im  = rand_word();
    e.last   = last;
    return e;
  endfunction

  task automatic send_beat(input elem_t e, input bit use_want, input y_result_t want);
    y_result_t pred;
    bit has;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {e.oy_im, e.oy_re, e.vec_im, e.vec_re, e.mat_im, e.mat_re};
    in_tlast  <= e.last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    has = update_column(e, pred);
    if (has) y_expected_q.push_back(use_want ? want : pred);
  endtask

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
  endtask

  task automatic wait_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (y_expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_config(input logic signed [DW-1:0] a_re, input logic signed [DW-1:0] a_im,
                            input bit cj, input bit xcj);
    wait_results();
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_ALPHA_RE;
    cfg_wdata <= a_re;
    @(negedge clk);
    cfg_addr  <= CFG_ALPHA_IM;
    cfg_wdata <= a_im;
    @(negedge clk);
    cfg_addr  <= CFG_CONJ_MODE;
    cfg_wdata <= DW'(cj);
    @(negedge clk);
    cfg_addr  <= CFG_XCONJ_MODE;
    cfg_wdata <= DW'(xcj);
    @(negedge clk);
    cfg_we    <= 1'b0;
    alpha_re_q = a_re;
    alpha_im_q = a_im;
    conj_q     = cj;
    xconj_q    = xcj;
  endtask

  // receiver: free flow, random stalls, mostly ready, or a solid stall
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = (rx_mode == 3) ? $urandom_range(1, 12) : $urandom_range(1, 40);
    end
    rx_left--;
    case (rx_mode)
      0:       out_tready <= 1'b1;
      1:       out_tready <= ($urandom_range(0, 1) != 0);
      2:       out_tready <= ($urandom_range(0, 3) != 0);
      default: out_tready <= 1'b0;
    endcase
  end

  always @(posedge clk) begin
    y_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (y_expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: y %0d,%0d sat %0d", $signed(out_tdata[DW-1:0]),
                   $signed(out_tdata[2*DW-1:DW]), out_tuser);
      end else begin
        want = y_expected_q.pop_front();
        if (out_tdata[DW-1:0] !== want.re || out_tdata[2*DW-1:DW] !== want.im ||
            out_tuser !== want.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("y mismatch: expected %0d,%0d sat %0d, got %0d,%0d sat %0d",
                     want.re, want.im, want.sat, $signed(out_tdata[DW-1:0]),
                     $signed(out_tdata[2*DW-1:DW]), out_tuser);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    elem_t     e;
    y_result_t want;
    dir_row_t  row;
    int        burst_left;
    int        sent;
    int        col_len;
    clk         = 1'b0;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_addr    = CFG_ALPHA_RE;
    cfg_wdata   = '0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    out_tready  = 1'b0;
    mismatches  = 0;
    cycle_count = 0;
    rx_left     = 0;
    rx_mode     = 0;
    burst_left  = 0;
    col_sum_re  = 0;
    col_sum_im  = 0;
    alpha_re_q  = DW'(1 << FRAC);
    alpha_im_q  = '0;
    conj_q      = 0;
    xconj_q     = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_DIR; i++) begin
      row = DIR_ROWS[i];
      if (row.set_cfg) set_config(row.a_re[DW-1:0], row.a_im[DW-1:0], row.cj, row.xcj);
      e.mat_re = row.m_re[DW-1:0];
      e.mat_im = row.m_im[DW-1:0];
      e.vec_re = row.v_re[DW-1:0];
      e.vec_im = row.v_im[DW-1:0];
      e.oy_re  = row.y_re[DW-1:0];
      e.oy_im  = row.y_im[DW-1:0];
      e.last   = row.last;
      want.re  = row.e_re[DW-1:0];
      want.im  = row.e_im[DW-1:0];
      want.sat = row.e_sat;
      send_beat(e, row.typed, want);
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       set_config(16'sd4096, 16'sd0, 0, 0);
        1:       set_config(16'sh7fff, 16'sh8000, 1, 0);
        2:       set_config(16'sh8000, 16'sh7fff, 0, 1);
        3:       set_config(16'sd0, 16'sd0, 1, 1);
        default: set_config(rand_word(), rand_word(), ($urandom_range(0, 1) != 0),
                            ($urandom_range(0, 1) != 0));
      endcase
      sent = 0;
      while (sent < PHASE_BEATS) begin
        col_len = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6) : $urandom_range(7, 30);
        for (int j = 0; j < col_len; j++) begin
          if (burst_left == 0) begin
            if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 8));
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 30);
          end
          burst_left--;
          if ($urandom_range(0, 199) == 0) wait_results();
          send_beat(rand_elem(j == col_len - 1), 0, want);
          sent++;
        end
      end
    end

    // long columns of extreme products, re up, then im down
    set_config(16'sd4096, 16'sd0, 0, 0);
    e = '{mat_re: 16'sh8000, mat_im: 16'sh7fff, vec_re: 16'sh8000, vec_im: 16'sh8000,
          oy_re: '0, oy_im: '0, last: 1'b0};
    for (int j = 0; j < SAT_RUN; j++) send_beat(e, 0, want);
    send_beat(rand_elem(1), 0, want);
    e = '{mat_re: 16'sh8000, mat_im: 16'sh8000, vec_re: 16'sh7fff, vec_im: 16'sh7fff,
          oy_re: '0, oy_im: '0, last: 1'b0};
    for (int j = 0; j < SAT_RUN; j++) send_beat(e, 0, want);
    send_beat(rand_elem(1), 0, want);

    wait_results();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
